// File: rtl/core/hics_pkg.sv
// ----------------------------------------------------------------------------
// hics_pkg: shared definitions for the histogram inverse-CDF sampler
// Widths, operation and status codes, sequencer states and the structs
// that travel between the sampler's modules.
// ----------------------------------------------------------------------------
package hics_pkg;

    // table geometry
    localparam int MAX_BINS   = 256;
    localparam int IDX_W      = $clog2(MAX_BINS);
    localparam int BIN_W      = IDX_W + 1;

    // field widths
    localparam int ENERGY_W   = 32;
    localparam int COUNT_W    = 24;
    localparam int RAND_W     = 16;
    localparam int SUM_W      = 32;

    // datapath widths
    localparam int Y_W        = RAND_W + SUM_W;
    localparam int PROD_W     = Y_W + ENERGY_W;
    localparam int MUL_CHUNKS = Y_W / RAND_W;
    localparam int CHUNK_W    = $clog2(MUL_CHUNKS);
    localparam int DIV_STEPS  = SUM_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS) + 1;

    // operation code of an input word
    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_SAMPLE = 1'b1
    } t_op;

    // result status
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FEW  = 2'd1,
        ST_FLAT = 2'd2,
        ST_SAT  = 2'd3
    } t_status;

    // sample sequencer
    typedef enum logic [3:0] {
        S_IDLE,
        S_SCALE,
        S_SRCH_ADDR,
        S_SRCH_CMP,
        S_RD0,
        S_RD1,
        S_RD2,
        S_PREP,
        S_MUL,
        S_ACC,
        S_DIV_GO,
        S_DIV_WAIT,
        S_FIN,
        S_OUT
    } t_state;

    // one bin load toward the table
    typedef struct packed {
        logic                en;
        logic                first;
        logic [ENERGY_W-1:0] energy;
        logic [COUNT_W-1:0]  count;
    } t_load_req;

    // divider status
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// File: rtl/core/hics_if.sv
// ----------------------------------------------------------------------------
// hics_if: valid/ready channels of the sampler
// Input channel carries load and sample words, output channel carries
// one sampled energy with its status.
// ----------------------------------------------------------------------------
interface hics_in_if;
    logic                              valid;
    logic                              ready;
    hics_pkg::t_op                     operation;
    logic                              first_bin;
    logic [hics_pkg::ENERGY_W-1:0]     bin_energy;
    logic [hics_pkg::COUNT_W-1:0]      bin_count;
    logic [hics_pkg::RAND_W-1:0]       uniform_value;

    modport source (
        output valid, operation, first_bin, bin_energy, bin_count, uniform_value,
        input  ready
    );
    modport sink (
        input  valid, operation, first_bin, bin_energy, bin_count, uniform_value,
        output ready
    );
endinterface

interface hics_out_if;
    logic                              valid;
    logic                              ready;
    logic [hics_pkg::ENERGY_W-1:0]     sampled_energy;
    hics_pkg::t_status                 status;

    modport source (
        output valid, sampled_energy, status,
        input  ready
    );
    modport sink (
        input  valid, sampled_energy, status,
        output ready
    );
endinterface

// File: rtl/core/hics_table.sv
// ----------------------------------------------------------------------------
// hics_table: histogram bin table
// Holds edge energies and cumulative counts (bin 0 count left out), keeps
// the bin fill count and the saturating total of all counts. At most one write
// per load, one registered read port for the sample sequencer.
// ----------------------------------------------------------------------------
module hics_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  hics_pkg::t_load_req           i_load,
    input  logic [hics_pkg::IDX_W-1:0]    i_rd_addr,
    output logic [hics_pkg::ENERGY_W-1:0] o_rd_energy,
    output logic [hics_pkg::SUM_W-1:0]    o_rd_cum,
    output logic [hics_pkg::BIN_W-1:0]    o_bins_loaded,
    output logic [hics_pkg::SUM_W-1:0]    o_total
);

    // saturating add of a count onto a 32-bit sum
    function automatic logic [hics_pkg::SUM_W-1:0] sat_add(
        input logic [hics_pkg::SUM_W-1:0]   a,
        input logic [hics_pkg::COUNT_W-1:0] b
    );
        logic [hics_pkg::SUM_W:0] s;
        s = {1'b0, a} + (hics_pkg::SUM_W + 1)'(b);
        return s[hics_pkg::SUM_W] ? '1 : s[hics_pkg::SUM_W-1:0];
    endfunction

    logic [hics_pkg::ENERGY_W-1:0] mem_energy [hics_pkg::MAX_BINS];
    logic [hics_pkg::SUM_W-1:0]    mem_cum    [hics_pkg::MAX_BINS];

    logic [hics_pkg::BIN_W-1:0]    r_bins;
    logic [hics_pkg::SUM_W-1:0]    r_total;
    logic [hics_pkg::SUM_W-1:0]    r_last_cum;
    logic [hics_pkg::ENERGY_W-1:0] r_rd_energy;
    logic [hics_pkg::SUM_W-1:0]    r_rd_cum;

    logic [hics_pkg::BIN_W-1:0]    bin_eff;
    logic [hics_pkg::SUM_W-1:0]    tot_eff;
    logic [hics_pkg::SUM_W-1:0]    cum_new;
    logic [hics_pkg::SUM_W-1:0]    tot_new;
    logic                          wr_ok;

    // first bin restarts the histogram; full table drops the load
    always_comb begin
        bin_eff = i_load.first ? '0 : r_bins;
        tot_eff = i_load.first ? '0 : r_total;
        wr_ok   = i_load.en && (bin_eff < hics_pkg::BIN_W'(hics_pkg::MAX_BINS));
        cum_new = (bin_eff == '0) ? '0 : sat_add(r_last_cum, i_load.count);
        tot_new = sat_add(tot_eff, i_load.count);
    end

    // table write and registered read
    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            mem_energy[bin_eff[hics_pkg::IDX_W-1:0]] <= i_load.energy;
            mem_cum[bin_eff[hics_pkg::IDX_W-1:0]]    <= cum_new;
            r_last_cum                               <= cum_new;
        end
        r_rd_energy <= mem_energy[i_rd_addr];
        r_rd_cum    <= mem_cum[i_rd_addr];
    end

    // fill count and total
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bins  <= '0;
            r_total <= '0;
        end else if (wr_ok) begin
            r_bins  <= bin_eff + 1'b1;
            r_total <= tot_new;
        end
    end

    assign o_rd_energy   = r_rd_energy;
    assign o_rd_cum      = r_rd_cum;
    assign o_bins_loaded = r_bins;
    assign o_total       = r_total;

endmodule

// File: rtl/core/hics_div.sv
// ----------------------------------------------------------------------------
// hics_div: serial restoring divider
// Divides a 64-bit dividend by a 32-bit divisor, one quotient bit per
// cycle. The caller guarantees the high half is below the divisor, so the
// quotient fits in 32 bits.
// ----------------------------------------------------------------------------
module hics_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [hics_pkg::SUM_W-1:0] i_num_hi,
    input  logic [hics_pkg::SUM_W-1:0] i_num_lo,
    input  logic [hics_pkg::SUM_W-1:0] i_den,
    output hics_pkg::t_div_stat        o_stat,
    output logic [hics_pkg::SUM_W-1:0] o_quot
);

    logic [hics_pkg::SUM_W-1:0]     r_rem;
    logic [hics_pkg::SUM_W-1:0]     r_quo;
    logic [hics_pkg::SUM_W-1:0]     r_den;
    logic [hics_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                           r_busy;
    logic                           r_done;

    logic [hics_pkg::SUM_W:0]       rem_sh;
    logic [hics_pkg::SUM_W:0]       rem_sub;
    logic                           ge;

    // one restoring step
    always_comb begin
        rem_sh  = {r_rem, r_quo[hics_pkg::SUM_W-1]};
        ge      = rem_sh >= {1'b0, r_den};
        rem_sub = rem_sh - {1'b0, r_den};
    end

    // payload: remainder, dividend/quotient shift register, divisor
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num_hi;
            r_quo <= i_num_lo;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? rem_sub[hics_pkg::SUM_W-1:0] : rem_sh[hics_pkg::SUM_W-1:0];
            r_quo <= {r_quo[hics_pkg::SUM_W-2:0], ge};
        end
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == hics_pkg::DIV_CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= hics_pkg::DIV_CNT_W'(hics_pkg::DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == hics_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quo;

endmodule

// File: rtl/core/histogram_inverse_cdf_sampler.sv
// ----------------------------------------------------------------------------
// histogram_inverse_cdf_sampler: piecewise-linear inverse-CDF energy sampler
// Loads a histogram one bin per word, then draws energies by scaling a
// uniform fraction by the total count, binary-searching the cumulative
// table and interpolating with a shared multiplier and a serial divider.
//
//   channel  dir  word                                             result
//   i_in     in   operation, first_bin, bin_energy, bin_count,     -
//                 uniform_value
//   o_out    out  sampled_energy, status                           1 per sample
//
// A load is accepted only in the idle state; ready stays high across loads.
// A sample runs 8 binary-search steps on the table's single read port, then
// interpolates with 16-bit slices on the 16x32 multiplier and the serial
// divider; a quotient too wide to fit skips the divider.
// Fewer than two bins goes straight to output; a flat interval skips both.
// Reset clears the fill count and the total; the table is not cleared.
// A result waiting on o_out does not block loads; the next sample holds
// in its final state until the output register is free.
// ----------------------------------------------------------------------------
module histogram_inverse_cdf_sampler (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hics_in_if.sink    i_in,
    hics_out_if.source o_out
);

    localparam int EW = hics_pkg::ENERGY_W;
    localparam int SW = hics_pkg::SUM_W;
    localparam int RW = hics_pkg::RAND_W;
    localparam int YW = hics_pkg::Y_W;
    localparam int PW = hics_pkg::PROD_W;
    localparam int IW = hics_pkg::IDX_W;
    localparam int BW = hics_pkg::BIN_W;

    hics_pkg::t_state    r_state, n_state;
    hics_pkg::t_load_req load_req;
    hics_pkg::t_div_stat div_stat;

    logic                        in_accept;
    logic                        div_start;
    logic [IW-1:0]               rd_addr;
    logic [EW-1:0]               rd_energy;
    logic [SW-1:0]               rd_cum;
    logic [BW-1:0]               bins_loaded;
    logic [SW-1:0]               total;
    logic [SW-1:0]               div_quot;

    // sequencer datapath registers
    logic [RW-1:0]               r_u;
    logic [YW-1:0]               r_y;
    logic [IW-1:0]               r_j;
    logic [IW-1:0]               r_bit;
    logic [SW-1:0]               r_c0, r_c1;
    logic [EW-1:0]               r_e0, r_e1;
    logic [YW-1:0]               r_num;
    logic [EW-1:0]               r_h;
    logic [SW-1:0]               r_diff;
    logic                        r_neg;
    logic [hics_pkg::CHUNK_W-1:0] r_k;
    logic [YW-1:0]               r_prod;
    logic [PW-1:0]               r_acc;
    logic                        r_ovf;
    logic [EW-1:0]               r_res;
    hics_pkg::t_status           r_stat;

    // output register
    logic                        r_out_valid;
    logic [EW-1:0]               r_out_energy;
    hics_pkg::t_status           r_out_status;

    logic [IW-1:0]               cand;
    logic                        srch_take;
    logic [RW-1:0]               mul_a;
    logic [SW-1:0]               mul_b;
    logic [YW-1:0]               mul_out;
    logic [YW-1:0]               base;
    logic                        out_free;
    logic [EW:0]                 up_sum;

    assign in_accept = i_in.valid && i_in.ready;
    assign out_free  = !r_out_valid || o_out.ready;

    // load words go straight to the table
    always_comb begin
        load_req.en     = in_accept && (i_in.operation == hics_pkg::OP_LOAD);
        load_req.first  = i_in.first_bin;
        load_req.energy = i_in.bin_energy;
        load_req.count  = i_in.bin_count;
    end

    hics_table u_table (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (load_req),
        .i_rd_addr     (rd_addr),
        .o_rd_energy   (rd_energy),
        .o_rd_cum      (rd_cum),
        .o_bins_loaded (bins_loaded),
        .o_total       (total)
    );

    hics_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_num_hi (r_acc[PW-1 -: SW]),
        .i_num_lo (r_acc[PW-SW-1 -: SW]),
        .i_den    (r_diff),
        .o_stat   (div_stat),
        .o_quot   (div_quot)
    );

    // shared multiplier: u*total for scaling, then 16-bit slices of num*h
    always_comb begin
        if (r_state == hics_pkg::S_SCALE) begin
            mul_a = r_u;
            mul_b = total;
        end else begin
            mul_a = r_num[r_k*RW +: RW];
            mul_b = r_h;
        end
        mul_out = YW'(mul_a) * YW'(mul_b);
    end

    // binary search: keep the candidate if it is in range and its
    // scaled cumulative count is at or below y
    assign cand      = r_j | r_bit;
    assign srch_take = ({1'b0, cand} <= (bins_loaded - BW'(2)))
                    && ({rd_cum, {RW{1'b0}}} <= r_y);
    assign base      = {r_c0, {RW{1'b0}}};
    assign up_sum    = {1'b0, r_e0} + (EW + 1)'(div_quot);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hics_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and control outputs
    always_comb begin
        n_state     = r_state;
        i_in.ready  = 1'b0;
        div_start   = 1'b0;
        rd_addr     = r_j;
        case (r_state)
            hics_pkg::S_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid && (i_in.operation == hics_pkg::OP_SAMPLE)) begin
                    n_state = (bins_loaded < BW'(2)) ? hics_pkg::S_OUT
                                                     : hics_pkg::S_SCALE;
                end
            end
            hics_pkg::S_SCALE:     n_state = hics_pkg::S_SRCH_ADDR;
            hics_pkg::S_SRCH_ADDR: begin
                rd_addr = cand;
                n_state = hics_pkg::S_SRCH_CMP;
            end
            hics_pkg::S_SRCH_CMP: begin
                n_state = r_bit[0] ? hics_pkg::S_RD0 : hics_pkg::S_SRCH_ADDR;
            end
            hics_pkg::S_RD0:       n_state = hics_pkg::S_RD1;
            hics_pkg::S_RD1: begin
                rd_addr = r_j + 1'b1;
                n_state = hics_pkg::S_RD2;
            end
            hics_pkg::S_RD2:       n_state = hics_pkg::S_PREP;
            hics_pkg::S_PREP: begin
                n_state = (r_c1 == r_c0) ? hics_pkg::S_OUT : hics_pkg::S_MUL;
            end
            hics_pkg::S_MUL:       n_state = hics_pkg::S_ACC;
            hics_pkg::S_ACC: begin
                n_state = (r_k == '0) ? hics_pkg::S_DIV_GO : hics_pkg::S_MUL;
            end
            hics_pkg::S_DIV_GO: begin
                // quotient of 2^32 or more saturates without dividing
                if (r_acc[PW-1 -: SW] >= r_diff) begin
                    n_state = hics_pkg::S_FIN;
                end else begin
                    div_start = 1'b1;
                    n_state   = hics_pkg::S_DIV_WAIT;
                end
            end
            hics_pkg::S_DIV_WAIT: begin
                if (div_stat.done) begin
                    n_state = hics_pkg::S_FIN;
                end
            end
            hics_pkg::S_FIN:       n_state = hics_pkg::S_OUT;
            hics_pkg::S_OUT: begin
                if (out_free) begin
                    n_state = hics_pkg::S_IDLE;
                end
            end
            default:               n_state = hics_pkg::S_IDLE;
        endcase
    end

    // sample datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            hics_pkg::S_IDLE: begin
                r_u    <= i_in.uniform_value;
                r_res  <= '0;
                r_stat <= hics_pkg::ST_FEW;
            end
            hics_pkg::S_SCALE: begin
                r_y   <= mul_out;
                r_j   <= '0;
                r_bit <= {1'b1, {(IW-1){1'b0}}};
            end
            hics_pkg::S_SRCH_CMP: begin
                if (srch_take) begin
                    r_j <= cand;
                end
                r_bit <= r_bit >> 1;
            end
            hics_pkg::S_RD1: begin
                r_c0 <= rd_cum;
                r_e0 <= rd_energy;
            end
            hics_pkg::S_RD2: begin
                r_c1 <= rd_cum;
                r_e1 <= rd_energy;
            end
            hics_pkg::S_PREP: begin
                // flat interval returns the bin's edge energy
                r_res  <= r_e0;
                r_stat <= hics_pkg::ST_FLAT;
                r_num  <= (r_y >= base) ? (r_y - base) : '0;
                r_diff <= (r_c1 >= r_c0) ? (r_c1 - r_c0) : (r_c0 - r_c1);
                r_neg  <= r_e1 < r_e0;
                r_h    <= (r_e1 < r_e0) ? (r_e0 - r_e1) : (r_e1 - r_e0);
                r_acc  <= '0;
                r_k    <= hics_pkg::CHUNK_W'(hics_pkg::MUL_CHUNKS - 1);
            end
            hics_pkg::S_MUL: begin
                r_prod <= mul_out;
            end
            hics_pkg::S_ACC: begin
                r_acc <= (r_acc << RW) + PW'(r_prod);
                r_k   <= r_k - 1'b1;
            end
            hics_pkg::S_DIV_GO: begin
                r_ovf <= r_acc[PW-1 -: SW] >= r_diff;
            end
            hics_pkg::S_FIN: begin
                if (!r_neg) begin
                    if (r_ovf || up_sum[EW]) begin
                        r_res  <= '1;
                        r_stat <= hics_pkg::ST_SAT;
                    end else begin
                        r_res  <= up_sum[EW-1:0];
                        r_stat <= hics_pkg::ST_OK;
                    end
                end else begin
                    if (r_ovf || (EW'(div_quot) > r_e0)) begin
                        r_res  <= '0;
                        r_stat <= hics_pkg::ST_SAT;
                    end else begin
                        r_res  <= r_e0 - EW'(div_quot);
                        r_stat <= hics_pkg::ST_OK;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == hics_pkg::S_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == hics_pkg::S_OUT && out_free) begin
            r_out_energy <= r_res;
            r_out_status <= r_stat;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.sampled_energy = r_out_energy;
    assign o_out.status         = r_out_status;

    // divider is only started when idle
    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider restarted while busy");

    // chosen bin and its successor lie inside the loaded table
    a_bin_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hics_pkg::S_RD0) |-> (({1'b0, r_j} + BW'(2)) <= bins_loaded))
        else $error("search index beyond loaded bins");

    // a finished sample lands in the output register
    a_result_posted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hics_pkg::S_OUT && out_free) |=> r_out_valid)
        else $error("result lost at output register");

    // saturated status always carries an end-of-range energy
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == hics_pkg::ST_SAT)
            |-> (r_out_energy == '0 || r_out_energy == '1))
        else $error("saturated status with in-range energy");

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for histogram_inverse_cdf_sampler
// Streams histogram loads and draws into the sampler with bursty input and
// a patterned output stall. An in-bench histogram predicts every draw, and
// each returned word is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int RANDOM_WORDS  = 750;
    localparam int TABLE_OVERRUN = 3;      // extra loads past a full table
    localparam int IDLE_LIMIT    = 4000;   // cycles with no handshake at all
    localparam int DRAIN_CYCLES  = 150;    // idle time after the last checked draw

    localparam int EW = hics_pkg::ENERGY_W;
    localparam int CW = hics_pkg::COUNT_W;
    localparam int RW = hics_pkg::RAND_W;
    localparam int SW = hics_pkg::SUM_W;
    localparam int YW = hics_pkg::Y_W;
    localparam int NB = hics_pkg::MAX_BINS;

    typedef struct packed {
        hics_pkg::t_op       op;
        logic                first;
        logic [EW-1:0]       energy;
        logic [CW-1:0]       count;
        logic [RW-1:0]       frac;
    } t_bin_word;

    typedef struct packed {
        logic [EW-1:0]       energy;
        hics_pkg::t_status   status;
    } t_draw;

    typedef enum int {RX_OPEN, RX_HOLD, RX_CHOPPY} t_rx_mode;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // channels and the block
    hics_in_if  in_if ();
    hics_out_if out_if ();

    histogram_inverse_cdf_sampler i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // bench-side drive registers, known from time zero
    logic      drv_valid = 1'b0;
    logic      drv_ready = 1'b0;
    t_bin_word drv_word  = '0;

    assign in_if.valid         = drv_valid;
    assign in_if.operation     = drv_word.op;
    assign in_if.first_bin     = drv_word.first;
    assign in_if.bin_energy    = drv_word.energy;
    assign in_if.bin_count     = drv_word.count;
    assign in_if.uniform_value = drv_word.frac;
    assign out_if.ready        = drv_ready;

    // words waiting to be sent, draws waiting to come back
    t_bin_word pending_words [$];
    t_draw     expected_draws [$];

    // predicted histogram
    logic [EW-1:0]       hist_energy [NB];
    logic [SW-1:0]       hist_cum    [NB];
    int                  bin_fill   = 0;
    logic [SW-1:0]       hist_total = '0;

    // bookkeeping
    int mismatches   = 0;
    int n_loads      = 0;
    int n_dropped    = 0;
    int n_draws      = 0;
    int n_checked    = 0;
    int draws_by_status [4] = '{0, 0, 0, 0};
    logic in_took    = 1'b0;
    int idle_cycles  = 0;
    int burst_left   = 8;
    int gap_left     = 0;
    int rdy_left     = 0;
    t_rx_mode rdy_mode = RX_OPEN;

    // running sum that sticks at all ones
    function automatic logic [SW-1:0] sat_sum(input logic [SW-1:0] a,
                                              input logic [CW-1:0] b);
        logic [SW:0] s;
        s = {1'b0, a} + (SW + 1)'(b);
        return s[SW] ? {SW{1'b1}} : s[SW-1:0];
    endfunction

    // apply one accepted word to the histogram; a draw queues its answer
    function automatic void histogram_step(input t_bin_word w);
        t_draw               r;
        logic [YW-1:0]       y, base, num, den;
        logic [127:0]        prod, q;
        logic [EW-1:0]       e0, e1, span;
        logic                neg;
        int                  n, j;
        if (w.op == hics_pkg::OP_LOAD) begin
            if (w.first) begin
                bin_fill   = 0;
                hist_total = '0;
            end
            n = bin_fill;
            if (n >= NB) begin
                n_dropped++;
                return;
            end
            hist_energy[n] = w.energy;
            hist_cum[n]    = (n == 0) ? '0 : sat_sum(hist_cum[n-1], w.count);
            hist_total     = sat_sum(hist_total, w.count);
            bin_fill       = n + 1;
            n_loads++;
            return;
        end
        n_draws++;
        n = bin_fill;
        if (n < 2) begin
            r.energy = '0;
            r.status = hics_pkg::ST_FEW;
        end else begin
            // scaled target, then walk down to the bin at or below it
            y = YW'(w.frac) * YW'(hist_total);
            j = n - 2;
            while (j > 0 && {hist_cum[j], {RW{1'b0}}} > y)
                j--;
            e0 = hist_energy[j];
            e1 = hist_energy[j+1];
            if (hist_cum[j+1] == hist_cum[j]) begin
                r.energy = e0;
                r.status = hics_pkg::ST_FLAT;
            end else begin
                base = {hist_cum[j], {RW{1'b0}}};
                num  = (y >= base) ? y - base : '0;
                den  = {hist_cum[j+1] - hist_cum[j], {RW{1'b0}}};
                neg  = e1 < e0;
                span = neg ? e0 - e1 : e1 - e0;
                prod = 128'(num) * 128'(span);
                q    = prod / 128'(den);
                r.status = hics_pkg::ST_OK;
                if (!neg) begin
                    if (q + 128'(e0) > 128'({EW{1'b1}})) begin
                        r.energy = {EW{1'b1}};
                        r.status = hics_pkg::ST_SAT;
                    end else begin
                        r.energy = e0 + q[EW-1:0];
                    end
                end else if (q > 128'(e0)) begin
                    r.energy = '0;
                    r.status = hics_pkg::ST_SAT;
                end else begin
                    r.energy = e0 - q[EW-1:0];
                end
            end
        end
        draws_by_status[r.status]++;
        expected_draws = {expected_draws, r};
    endfunction

    // stimulus helpers
    function automatic void queue_load(input logic first, input logic [EW-1:0] energy,
                                       input logic [CW-1:0] count);
        t_bin_word w;
        w.op     = hics_pkg::OP_LOAD;
        w.first  = first;
        w.energy = energy;
        w.count  = count;
        w.frac   = RW'($urandom);
        pending_words = {pending_words, w};
    endfunction

    function automatic void queue_draw(input logic [RW-1:0] frac);
        t_bin_word w;
        w.op     = hics_pkg::OP_SAMPLE;
        w.first  = 1'($urandom_range(0, 1));
        w.energy = EW'($urandom);
        w.count  = CW'($urandom);
        w.frac   = frac;
        pending_words = {pending_words, w};
    endfunction

    function automatic logic [RW-1:0] rand_fraction();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return RW'($urandom);
        endcase
    endfunction

    // style 0: small counts with zeros, 1: full range, 2: extremes only
    function automatic logic [CW-1:0] pick_count(input int style);
        case (style)
            0:       return ($urandom_range(0, 3) == 0) ? '0 : CW'($urandom_range(1, 1000));
            1:       return CW'($urandom);
            default: return $urandom_range(0, 1) ? '1 : '0;
        endcase
    endfunction

    // style 0: rising edges, 1: anything, 2: near the ends of the range
    function automatic logic [EW-1:0] pick_energy(input int style,
                                                  input logic [EW-1:0] prev);
        case (style)
            0: return prev + EW'($urandom_range(0, 1 << 20));
            1: return EW'($urandom);
            default: begin
                case ($urandom_range(0, 3))
                    0:       return '0;
                    1:       return '1;
                    2:       return ~EW'($urandom_range(0, 255));
                    default: return EW'($urandom_range(0, 255));
                endcase
            end
        endcase
    endfunction

    // input driver: bursts with random gaps between them
    always @(negedge i_clk) begin : drive_words
        logic      send;
        t_bin_word word;
        send = drv_valid && !in_took;
        word = drv_word;
        if (i_rst_n) begin
            if (in_took) begin
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    case ($urandom_range(0, 5))
                        0, 1:    gap_left = 0;
                        2, 3:    gap_left = $urandom_range(1, 8);
                        4:       gap_left = $urandom_range(9, 30);
                        default: gap_left = $urandom_range(31, 90);
                    endcase
                end
            end
            if (!send) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_words.size() > 0) begin
                    word = pending_words.pop_front();
                    send = 1'b1;
                end
            end
        end
        drv_valid <= send;
        drv_word  <= word;
    end

    // output stall pattern: open stretches, hold-offs and choppy stretches
    always @(negedge i_clk) begin : stall_pattern
        if (rdy_left == 0) begin
            case ($urandom_range(0, 3))
                0: begin
                    rdy_mode = RX_OPEN;
                    rdy_left = $urandom_range(50, 200);
                end
                1: begin
                    rdy_mode = RX_HOLD;
                    rdy_left = $urandom_range(1, 40);
                end
                default: begin
                    rdy_mode = RX_CHOPPY;
                    rdy_left = $urandom_range(10, 60);
                end
            endcase
        end
        rdy_left--;
        case (rdy_mode)
            RX_OPEN:  drv_ready <= 1'b1;
            RX_HOLD:  drv_ready <= 1'b0;
            default:  drv_ready <= ($urandom_range(0, 2) != 0);
        endcase
    end

    // monitor: predict on input handshakes, check on output handshakes
    always @(posedge i_clk) begin : watch_ports
        t_bin_word seen;
        t_draw     want;
        if (!i_rst_n) begin
            in_took <= 1'b0;
        end else begin
            in_took <= in_if.valid && in_if.ready;
            if (in_if.valid && in_if.ready) begin
                seen.op     = in_if.operation;
                seen.first  = in_if.first_bin;
                seen.energy = in_if.bin_energy;
                seen.count  = in_if.bin_count;
                seen.frac   = in_if.uniform_value;
                histogram_step(seen);
            end
            if (out_if.valid && out_if.ready) begin
                if (expected_draws.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected draw, expected none, got energy %h status %0d",
                             $time, out_if.sampled_energy, out_if.status);
                end else begin
                    want = expected_draws.pop_front();
                    n_checked++;
                    if (out_if.sampled_energy !== want.energy) begin
                        mismatches++;
                        $display("%0t: draw %0d energy: expected %h, got %h",
                                 $time, n_checked, want.energy, out_if.sampled_energy);
                    end
                    if (out_if.status !== want.status) begin
                        mismatches++;
                        $display("%0t: draw %0d status: expected %0d, got %0d",
                                 $time, n_checked, want.status, out_if.status);
                    end
                end
            end
            // watchdog on handshake activity
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no handshake for %0d cycles, %0d draws outstanding",
                         $time, IDLE_LIMIT, expected_draws.size());
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    // stimulus and end of run
    initial begin : run_test
        logic [EW-1:0]       energy;
        int                  target, nbins, kind, e_style, c_style;
        bit                  full_done;
        full_done = 1'b0;

        // directed: empty table, first flag ignored on a draw
        queue_draw('1);
        // one bin loaded without the first flag right after reset
        queue_load(1'b0, '0, '1);
        queue_draw(16'h1234);
        // zero span: flat answer at both ends of the fraction
        queue_load(1'b0, '1, '0);
        queue_draw('0);
        queue_draw('1);
        // plain rising histogram
        queue_load(1'b1, 32'd1000, '0);
        queue_load(1'b0, 32'd2000, 24'd100);
        queue_load(1'b0, 32'd3000, 24'd100);
        queue_draw('0);
        queue_draw(16'h8000);
        queue_draw('1);
        // target past the last cumulative count, clipped at the top
        queue_load(1'b1, 32'hFFFF_FF00, '1);
        queue_load(1'b0, '1, 24'd1);
        queue_draw('1);
        // falling energies, clipped at zero, and an exact hit
        queue_load(1'b1, 32'd100, '1);
        queue_load(1'b0, '0, 24'd1);
        queue_draw('1);
        queue_draw('0);
        // all-zero counts
        queue_load(1'b1, 32'd5, '0);
        queue_load(1'b0, 32'd7, '0);
        queue_draw(16'h4321);

        // random histograms, mostly well formed, one filled to the top
        target = pending_words.size() + RANDOM_WORDS + TABLE_OVERRUN;
        while (pending_words.size() < target) begin
            nbins = $urandom_range(2, 12);
            kind  = $urandom_range(0, 7);
            if (!full_done && pending_words.size() > target / 2) begin
                nbins     = NB;
                kind      = 1;
                full_done = 1'b1;
            end
            if (kind == 0) begin
                // loose loads and draws
                repeat ($urandom_range(1, 6)) begin
                    if ($urandom_range(0, 1))
                        queue_load(1'($urandom_range(0, 1)), EW'($urandom),
                                   CW'($urandom));
                    else
                        queue_draw(rand_fraction());
                end
            end else begin
                e_style = $urandom_range(0, 2);
                c_style = $urandom_range(0, 2);
                energy  = EW'($urandom);
                for (int b = 0; b < nbins; b++) begin
                    energy = pick_energy(e_style, energy);
                    // now and then a histogram is appended to the previous one
                    queue_load((b == 0) && (nbins == NB || $urandom_range(0, 5) != 0),
                               energy, pick_count(c_style));
                    if (b > 0 && $urandom_range(0, 7) == 0)
                        queue_draw(rand_fraction());
                end
                if (nbins == NB)
                    repeat (TABLE_OVERRUN)
                        queue_load(1'b0, EW'($urandom), CW'($urandom));
                repeat ($urandom_range(1, 8))
                    queue_draw(rand_fraction());
            end
        end

        // reset, then let the driver empty the queue
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        while (pending_words.size() != 0 || drv_valid)
            @(posedge i_clk);
        while (expected_draws.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d bin loads (%0d dropped on a full table) and %0d draws",
                 n_loads, n_dropped, n_draws);
        $display("draws by status: ok %0d, few bins %0d, flat %0d, saturated %0d",
                 draws_by_status[hics_pkg::ST_OK], draws_by_status[hics_pkg::ST_FEW],
                 draws_by_status[hics_pkg::ST_FLAT], draws_by_status[hics_pkg::ST_SAT]);
        if (mismatches == 0 && expected_draws.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
